// ===== design/i2cra_pkg.sv =====
// Package for the I2C register-access master: phase codes, stop kinds, command codes,
// register indexes, the front/back queue entry type and the result and config types. No dependencies.
`default_nettype none
package i2cra_pkg;
  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_ST_D, PH_TX_BIT, PH_TX_HI, PH_TX_REL,
    PH_TX_POLL, PH_TX_CLKLO, PH_TX_END, PH_RX_LO, PH_RX_HI, PH_RX_SAMPLE,
    PH_RX_NACK_HI, PH_SP_A, PH_SP_B, PH_SP_C, PH_SP_D, PH_GAP
  } phase_t;

  typedef enum logic [1:0] {
    STOP_OK, STOP_FAIL, STOP_RETRY, STOP_RETRY_GAP
  } stop_kind_t;

  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_MASKED = 2'd3;

  localparam logic [1:0] REG_DEV = 2'd0;
  localparam logic [1:0] REG_ATT = 2'd1;
  localparam logic [1:0] REG_POLL = 2'd2;
  localparam logic [1:0] REG_GAP = 2'd3;

  localparam int QDEPTH = 2;

  // one tick as queued by the front end
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] bit_mask;
    logic       sda_level;
    logic       scl_level;
  } tick_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic       success;
    logic [7:0] read_data;
  } result_t;

  typedef struct packed {
    logic [7:0]  dev;
    logic [2:0]  attempts;
    logic [3:0]  poll;
    logic [15:0] gap;
  } cfg_t;
endpackage
`default_nettype wire

// ===== design/i2cra_front.sv =====
// Front end: accepts ticks from the input stream and queues them.
// Depends on i2cra_pkg.
`default_nettype none
module i2cra_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire i2cra_pkg::tick_t in_tick,
  output logic                  q_valid,
  input  wire logic             q_take,
  output i2cra_pkg::tick_t      q_tick
);
  import i2cra_pkg::*;
  tick_t      mem [QDEPTH];
  logic       wp, rp;
  logic [1:0] count;

  assign in_ready = (count != 2'(QDEPTH));
  assign q_valid  = (count != 2'd0);
  assign q_tick   = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= in_tick;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (q_take) rp <= ~rp;
      count <= count + 2'(in_valid && in_ready) - 2'(q_take);
    end
  end
endmodule
`default_nettype wire

// ===== design/i2cra_back.sv =====
// Back end: the bus sequencer. Runs one tick per queued item and keeps a
// one-entry output register. Depends on i2cra_pkg.
`default_nettype none
module i2cra_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire i2cra_pkg::cfg_t  cfg,
  input  wire logic             q_valid,
  output logic                  q_take,
  input  wire i2cra_pkg::tick_t q_tick,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output i2cra_pkg::result_t    out_res
);
  import i2cra_pkg::*;
  phase_t     phase, phase_next;
  stop_kind_t stop_kind, stop_kind_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_byte, shift_byte_next, received_byte, received_byte_next;
  logic [2:0] attempts_left, attempts_left_next;
  logic [3:0] seq_step, seq_step_next;
  logic [15:0] wait_count, wait_count_next;
  logic [1:0] pending_command, pending_command_next;
  logic [7:0] held_reg_addr, held_reg_addr_next, held_data, held_data_next;
  logic [7:0] held_mask, held_mask_next;
  logic ack_seen, ack_seen_next, scl_drv, scl_drv_next, sda_drv, sda_drv_next;
  logic done, ok;
  logic [3:0] bstep;
  logic       bgo;
  logic [3:0] bc_inc;

  assign q_take = q_valid && (!out_valid || out_ready);
  assign bc_inc = bit_count + 4'd1;

  always_comb begin
    phase_next = phase; stop_kind_next = stop_kind; bit_count_next = bit_count;
    shift_byte_next = shift_byte; received_byte_next = received_byte;
    attempts_left_next = attempts_left; seq_step_next = seq_step;
    wait_count_next = wait_count; pending_command_next = pending_command;
    held_reg_addr_next = held_reg_addr; held_data_next = held_data;
    held_mask_next = held_mask; ack_seen_next = ack_seen;
    scl_drv_next = scl_drv; sda_drv_next = sda_drv;
    done = 1'b0; ok = 1'b0; bgo = 1'b0; bstep = 4'd0;
    unique case (phase)
      PH_IDLE: begin
        scl_drv_next = 1'b1; sda_drv_next = 1'b1;
        if (q_tick.command != CMD_NONE) begin
          pending_command_next = q_tick.command;
          held_reg_addr_next = q_tick.reg_addr;
          held_data_next = q_tick.write_data;
          held_mask_next = q_tick.bit_mask;
          bgo = 1'b1; bstep = (q_tick.command == CMD_WRITE) ? 4'd5 : 4'd0;
        end
      end
      PH_ST_A: begin sda_drv_next = 1'b1; phase_next = PH_ST_B; end
      PH_ST_B: begin scl_drv_next = 1'b1; phase_next = PH_ST_C; end
      PH_ST_C: begin
        if (!q_tick.sda_level || !q_tick.scl_level) begin
          stop_kind_next = STOP_RETRY; phase_next = PH_SP_A;
        end else begin
          sda_drv_next = 1'b0; phase_next = PH_ST_D;
        end
      end
      PH_ST_D: begin
        scl_drv_next = 1'b0;
        shift_byte_next = (seq_step == 4'd2) ? (cfg.dev | 8'h01) : (cfg.dev & 8'hFE);
        bit_count_next = 4'd0; phase_next = PH_TX_BIT;
      end
      PH_TX_BIT: begin
        scl_drv_next = 1'b0; sda_drv_next = shift_byte[7]; phase_next = PH_TX_HI;
      end
      PH_TX_HI: begin
        scl_drv_next = 1'b1; shift_byte_next = {shift_byte[6:0], 1'b0};
        bit_count_next = bc_inc;
        phase_next = (bc_inc >= 4'd8) ? PH_TX_REL : PH_TX_BIT;
      end
      PH_TX_REL: begin
        scl_drv_next = 1'b0; sda_drv_next = 1'b1;
        wait_count_next = (cfg.poll != 4'd0) ? {12'd0, cfg.poll} : 16'd1;
        phase_next = PH_TX_POLL;
      end
      PH_TX_POLL: begin
        if (!q_tick.sda_level) begin
          ack_seen_next = 1'b1; scl_drv_next = 1'b1; phase_next = PH_TX_CLKLO;
        end else begin
          if (wait_count != 16'd0) wait_count_next = wait_count - 16'd1;
          if (wait_count <= 16'd1) begin
            ack_seen_next = 1'b0; scl_drv_next = 1'b1; phase_next = PH_TX_CLKLO;
          end
        end
      end
      PH_TX_CLKLO: begin scl_drv_next = 1'b0; phase_next = PH_TX_END; end
      PH_TX_END: begin
        sda_drv_next = 1'b0;
        if (ack_seen) begin
          bgo = 1'b1; bstep = seq_step + 4'd1;
        end else if (seq_step == 4'd0 || seq_step == 4'd2 || seq_step == 4'd5) begin
          stop_kind_next = STOP_RETRY_GAP; phase_next = PH_SP_A;
        end else begin
          stop_kind_next = STOP_FAIL; phase_next = PH_SP_A;
        end
      end
      PH_RX_LO: begin
        scl_drv_next = 1'b0; sda_drv_next = 1'b1; phase_next = PH_RX_HI;
      end
      PH_RX_HI: begin scl_drv_next = 1'b1; phase_next = PH_RX_SAMPLE; end
      PH_RX_SAMPLE: begin
        received_byte_next = {received_byte[6:0], q_tick.sda_level};
        bit_count_next = bc_inc;
        scl_drv_next = 1'b0; sda_drv_next = 1'b1;
        phase_next = (bc_inc >= 4'd8) ? PH_RX_NACK_HI : PH_RX_HI;
      end
      PH_RX_NACK_HI: begin scl_drv_next = 1'b1; bgo = 1'b1; bstep = 4'd4; end
      PH_SP_A: begin scl_drv_next = 1'b0; phase_next = PH_SP_B; end
      PH_SP_B: begin sda_drv_next = 1'b0; phase_next = PH_SP_C; end
      PH_SP_C: begin scl_drv_next = 1'b1; phase_next = PH_SP_D; end
      PH_SP_D: begin
        sda_drv_next = 1'b1;
        unique case (stop_kind)
          STOP_OK: begin
            if (seq_step == 4'd4 && pending_command == CMD_MASKED) begin
              held_data_next = (received_byte & ~held_mask) | (held_data & held_mask);
              bgo = 1'b1; bstep = 4'd5;
            end else begin
              done = 1'b1; ok = 1'b1; phase_next = PH_IDLE;
            end
          end
          STOP_FAIL: begin done = 1'b1; phase_next = PH_IDLE; end
          default: begin
            if (attempts_left != 3'd0) attempts_left_next = attempts_left - 3'd1;
            if (attempts_left <= 3'd1) begin
              done = 1'b1; phase_next = PH_IDLE;
            end else if (stop_kind == STOP_RETRY) phase_next = PH_ST_A;
            else begin
              wait_count_next = cfg.gap; phase_next = PH_GAP;
            end
          end
        endcase
      end
      PH_GAP: begin
        if (wait_count == 16'd0) phase_next = PH_ST_A;
        else wait_count_next = wait_count - 16'd1;
      end
      default: begin
        scl_drv_next = 1'b1; sda_drv_next = 1'b1; phase_next = PH_IDLE;
      end
    endcase
    // start of a sequence step
    if (bgo) begin
      seq_step_next = bstep;
      case (bstep)
        4'd0, 4'd2, 4'd5: begin
          attempts_left_next = (cfg.attempts != 3'd0) ? cfg.attempts : 3'd1;
          phase_next = PH_ST_A;
        end
        4'd1, 4'd6: begin
          shift_byte_next = held_reg_addr_next; bit_count_next = 4'd0;
          phase_next = PH_TX_BIT;
        end
        4'd7: begin
          shift_byte_next = held_data_next; bit_count_next = 4'd0;
          phase_next = PH_TX_BIT;
        end
        4'd3: begin
          received_byte_next = 8'd0; bit_count_next = 4'd0; phase_next = PH_RX_LO;
        end
        default: begin stop_kind_next = STOP_OK; phase_next = PH_SP_A; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; stop_kind <= STOP_OK; bit_count <= 4'd0;
      shift_byte <= 8'd0; received_byte <= 8'd0; attempts_left <= 3'd0;
      seq_step <= 4'd0; wait_count <= 16'd0; pending_command <= CMD_NONE;
      held_reg_addr <= 8'd0; held_data <= 8'd0; held_mask <= 8'd0;
      ack_seen <= 1'b0; scl_drv <= 1'b1; sda_drv <= 1'b1; out_valid <= 1'b0;
    end else begin
      if (q_take) begin
        phase <= phase_next; stop_kind <= stop_kind_next;
        bit_count <= bit_count_next; shift_byte <= shift_byte_next;
        received_byte <= received_byte_next; attempts_left <= attempts_left_next;
        seq_step <= seq_step_next; wait_count <= wait_count_next;
        pending_command <= pending_command_next;
        held_reg_addr <= held_reg_addr_next; held_data <= held_data_next;
        held_mask <= held_mask_next; ack_seen <= ack_seen_next;
        scl_drv <= scl_drv_next; sda_drv <= sda_drv_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      out_res.scl_release <= scl_drv_next;
      out_res.sda_release <= sda_drv_next;
      out_res.busy_res <= (phase_next != PH_IDLE);
      out_res.done_res <= done;
      out_res.success <= done && ok;
      out_res.read_data <= (done && ok && pending_command_next != CMD_WRITE)
                           ? received_byte_next : 8'd0;
    end
  end
endmodule
`default_nettype wire

// ===== design/i2c_master_register_access_top.sv =====
// Top level of the I2C register-access master: APB register file, stream
// ports, front queue and bus sequencer. Depends on i2cra_pkg, i2cra_front, i2cra_back.
`default_nettype none
// Each input item is one bit-time tick of the bus: the sampled SDA/SCL levels
// plus, while idle, a command (1 write, 2 read, 3 masked read-modify-write).
// Each tick yields exactly one result item with the open-drain releases for
// the next tick and status (busy, done, success, read_data). Throughput is
// one item per clock unless m_tready stalls; items pass the two-entry input
// queue, then the sequencer updates its state and output register together.
// Registers (APB, byte address 4*i): device address, start attempts, ack poll
// ticks, retry gap ticks. Write them only while no command is in flight.
module i2c_master_register_access_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // command[1:0], reg_addr[9:2], write_data[17:10], bit_mask[25:18],
  // sda_level[26], scl_level[27], zero fill [31:28]
  input  wire logic [31:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // scl_release[0], sda_release[1], busy_res[2], done_res[3], success[4],
  // read_data[12:5], zero fill [15:13]
  output logic [15:0]      m_tdata
);
  import i2cra_pkg::*;
  cfg_t    cfg;
  tick_t   in_tick, q_tick;
  result_t res;
  logic    q_valid, q_take;
  logic    wr;
  logic [1:0] ridx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign ridx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dev <= 8'd0; cfg.attempts <= 3'd3; cfg.poll <= 4'd5; cfg.gap <= 16'd16;
    end else if (wr && paddr[1:0] == 2'd0) begin
      unique case (ridx)
        REG_DEV:  cfg.dev <= pwdata[7:0];
        REG_ATT:  cfg.attempts <= pwdata[2:0];
        REG_POLL: cfg.poll <= pwdata[3:0];
        REG_GAP:  cfg.gap <= pwdata[15:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_DEV:  prdata = {24'd0, cfg.dev};
      REG_ATT:  prdata = {29'd0, cfg.attempts};
      REG_POLL: prdata = {28'd0, cfg.poll};
      REG_GAP:  prdata = {16'd0, cfg.gap};
      default:  prdata = 32'd0;
    endcase
  end

  assign in_tick = '{command: s_tdata[1:0], reg_addr: s_tdata[9:2],
                     write_data: s_tdata[17:10], bit_mask: s_tdata[25:18],
                     sda_level: s_tdata[26], scl_level: s_tdata[27]};

  i2cra_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .in_tick(in_tick), .q_valid(q_valid), .q_take(q_take), .q_tick(q_tick)
  );

  i2cra_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_take(q_take),
    .q_tick(q_tick), .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );

  assign m_tdata = {3'd0, res.read_data, res.success, res.done_res,
                    res.busy_res, res.sda_release, res.scl_release};

  // success only ever comes with done
  a_succ_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!res.success || res.done_res))
    else $error("success without done");
  // a finished transaction reports not busy
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.done_res |-> !res.busy_res)
    else $error("done while busy");
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed under stall");
endmodule
`default_nettype wire

// ===== tb/sv/i2cra_checker.sv =====
// Checker for the I2C register-access master: follows the APB writes, predicts
// one result item per accepted tick item and compares. Depends on i2cra_pkg.
`timescale 1ns / 1ps
module i2cra_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  output int          errors,
  output logic        bus_idle,
  output int          awaiting
);
  import i2cra_pkg::*;
  // register copy
  logic [7:0]  dev_byte;
  logic [2:0]  tries_cfg;
  logic [3:0]  poll_cfg;
  logic [15:0] gap_cfg;

  // sequencer copy
  phase_t      ph;
  stop_kind_t  sk;
  logic [3:0]  nbit, leg;
  logic [7:0]  sh, rx, a_reg, a_dat, a_msk;
  logic [2:0]  tries;
  logic [15:0] cnt;
  logic [1:0]  op;
  logic        acked, scl_o, sda_o, fin, good;

  result_t     bus_results[$];

  task automatic report(input string what, input int exp_v, input int got_v);
    $display("%0t mismatch %s: expected %0h got %0h", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  task automatic enter_leg(input logic [3:0] s);
    leg = s;
    case (s)
      4'd0, 4'd2, 4'd5: begin
        tries = (tries_cfg != 0) ? tries_cfg : 3'd1;
        ph = PH_ST_A;
      end
      4'd1, 4'd6: begin
        sh = a_reg; nbit = 0; ph = PH_TX_BIT;
      end
      4'd7: begin
        sh = a_dat; nbit = 0; ph = PH_TX_BIT;
      end
      4'd3: begin
        rx = 0; nbit = 0; ph = PH_RX_LO;
      end
      default: begin
        sk = STOP_OK; ph = PH_SP_A;
      end
    endcase
  endtask

  task automatic start_stop(input stop_kind_t k);
    sk = k;
    ph = PH_SP_A;
  endtask

  task automatic close_out(input logic ok);
    ph = PH_IDLE; fin = 1; good = ok;
  endtask

  // one bit-time tick of the bus sequencer
  task automatic bus_tick(input tick_t t, output result_t r);
    fin = 0; good = 0;
    case (ph)
      PH_IDLE: begin
        scl_o = 1; sda_o = 1;
        if (t.command != CMD_NONE) begin
          op = t.command; a_reg = t.reg_addr; a_dat = t.write_data; a_msk = t.bit_mask;
          enter_leg(t.command == CMD_WRITE ? 4'd5 : 4'd0);
        end
      end
      PH_ST_A: begin sda_o = 1; ph = PH_ST_B; end
      PH_ST_B: begin scl_o = 1; ph = PH_ST_C; end
      PH_ST_C: begin
        // bus must be free before START
        if (!t.sda_level || !t.scl_level) start_stop(STOP_RETRY);
        else begin sda_o = 0; ph = PH_ST_D; end
      end
      PH_ST_D: begin
        scl_o = 0;
        sh = (leg == 4'd2) ? (dev_byte | 8'h01) : (dev_byte & 8'hFE);
        nbit = 0; ph = PH_TX_BIT;
      end
      PH_TX_BIT: begin scl_o = 0; sda_o = sh[7]; ph = PH_TX_HI; end
      PH_TX_HI: begin
        scl_o = 1; sh = sh << 1; nbit = nbit + 1;
        ph = (nbit >= 8) ? PH_TX_REL : PH_TX_BIT;
      end
      PH_TX_REL: begin
        scl_o = 0; sda_o = 1;
        cnt = (poll_cfg != 0) ? 16'(poll_cfg) : 16'd1;
        ph = PH_TX_POLL;
      end
      PH_TX_POLL: begin
        if (!t.sda_level) begin acked = 1; scl_o = 1; ph = PH_TX_CLKLO; end
        else begin
          if (cnt > 0) cnt--;
          if (cnt == 0) begin acked = 0; scl_o = 1; ph = PH_TX_CLKLO; end
        end
      end
      PH_TX_CLKLO: begin scl_o = 0; ph = PH_TX_END; end
      PH_TX_END: begin
        sda_o = 0;
        if (acked) enter_leg(leg + 4'd1);
        else if (leg == 4'd0 || leg == 4'd2 || leg == 4'd5) start_stop(STOP_RETRY_GAP);
        else start_stop(STOP_FAIL);
      end
      PH_RX_LO: begin scl_o = 0; sda_o = 1; ph = PH_RX_HI; end
      PH_RX_HI: begin scl_o = 1; ph = PH_RX_SAMPLE; end
      PH_RX_SAMPLE: begin
        rx = {rx[6:0], t.sda_level}; nbit = nbit + 1;
        scl_o = 0; sda_o = 1;
        ph = (nbit >= 8) ? PH_RX_NACK_HI : PH_RX_HI;
      end
      PH_RX_NACK_HI: begin scl_o = 1; enter_leg(4'd4); end
      PH_SP_A: begin scl_o = 0; ph = PH_SP_B; end
      PH_SP_B: begin sda_o = 0; ph = PH_SP_C; end
      PH_SP_C: begin scl_o = 1; ph = PH_SP_D; end
      PH_SP_D: begin
        sda_o = 1;
        if (sk == STOP_OK) begin
          // masked write: merge the read byte, then run the write legs
          if (leg == 4'd4 && op == CMD_MASKED) begin
            a_dat = (rx & ~a_msk) | (a_dat & a_msk);
            enter_leg(4'd5);
          end else close_out(1);
        end else if (sk == STOP_FAIL) close_out(0);
        else begin
          if (tries > 0) tries--;
          if (tries == 0) close_out(0);
          else if (sk == STOP_RETRY) ph = PH_ST_A;
          else begin cnt = gap_cfg; ph = PH_GAP; end
        end
      end
      PH_GAP: begin
        if (cnt == 0) ph = PH_ST_A;
        else cnt--;
      end
      default: begin scl_o = 1; sda_o = 1; ph = PH_IDLE; end
    endcase
    r.scl_release = scl_o;
    r.sda_release = sda_o;
    r.busy_res    = (ph != PH_IDLE);
    r.done_res    = fin;
    r.success     = fin & good;
    r.read_data   = (fin && good && op != CMD_WRITE) ? rx : 8'h00;
  endtask

  always @(posedge clk) begin
    tick_t   t;
    result_t e, g;
    if (rst) begin
      dev_byte = 0; tries_cfg = 3; poll_cfg = 5; gap_cfg = 16;
      ph = PH_IDLE; sk = STOP_OK; nbit = 0; leg = 0; sh = 0; rx = 0;
      a_reg = 0; a_dat = 0; a_msk = 0; tries = 0; cnt = 0; op = CMD_NONE;
      acked = 0; scl_o = 1; sda_o = 1;
      bus_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_DEV:  dev_byte  = pwdata[7:0];
          REG_ATT:  tries_cfg = pwdata[2:0];
          REG_POLL: poll_cfg  = pwdata[3:0];
          REG_GAP:  gap_cfg   = pwdata[15:0];
        endcase
      end
      if (s_tvalid && s_tready) begin
        t.command    = s_tdata[1:0];
        t.reg_addr   = s_tdata[9:2];
        t.write_data = s_tdata[17:10];
        t.bit_mask   = s_tdata[25:18];
        t.sda_level  = s_tdata[26];
        t.scl_level  = s_tdata[27];
        bus_tick(t, e);
        bus_results.push_back(e);
      end
      if (m_tvalid && m_tready) begin
        g.scl_release = m_tdata[0];
        g.sda_release = m_tdata[1];
        g.busy_res    = m_tdata[2];
        g.done_res    = m_tdata[3];
        g.success     = m_tdata[4];
        g.read_data   = m_tdata[12:5];
        if (bus_results.size() == 0) report("unexpected item", 0, int'(m_tdata));
        else begin
          e = bus_results.pop_front();
          if (e.scl_release != g.scl_release) report("scl_release", e.scl_release, g.scl_release);
          if (e.sda_release != g.sda_release) report("sda_release", e.sda_release, g.sda_release);
          if (e.busy_res != g.busy_res) report("busy_res", e.busy_res, g.busy_res);
          if (e.done_res != g.done_res) report("done_res", e.done_res, g.done_res);
          if (e.success != g.success) report("success", e.success, g.success);
          if (e.read_data != g.read_data) report("read_data", e.read_data, g.read_data);
        end
      end
    end
    bus_idle <= (ph == PH_IDLE);
    awaiting <= bus_results.size();
  end

  initial errors = 0;
endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the I2C register-access master: clock, reset, APB writes,
// tick stimulus and verdict. Depends on i2cra_pkg, i2cra_checker and the block.
`timescale 1ns / 1ps
module tb_top;
  import i2cra_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 0;
  logic        s_tready;
  // command[1:0], reg_addr[9:2], write_data[17:10], bit_mask[25:18],
  // sda_level[26], scl_level[27]
  logic [31:0] s_tdata = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  // scl_release[0], sda_release[1], busy_res[2], done_res[3], success[4],
  // read_data[12:5]
  logic [15:0] m_tdata;

  int   errors;
  logic bus_idle;
  int   awaiting;
  logic calm = 0;      // no idling on either side while set
  int   sda_hi_pct = 75; // odds that the sampled SDA is high

  always #5 clk = ~clk;

  i2c_master_register_access_top u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  i2cra_checker u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .bus_idle(bus_idle), .awaiting(awaiting)
  );

  // receiver stalls with odds of about 22 in a hundred
  always @(posedge clk)
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 22);

  // APB write: setup cycle, then access cycle
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // present one tick item and hold it until taken
  task automatic put_tick(input logic [1:0] cmd, input logic [7:0] ra,
                          input logic [7:0] wd, input logic [7:0] mk,
                          input logic sda, input logic scl);
    s_tvalid <= 1;
    s_tdata  <= {4'b0, scl, sda, mk, wd, ra, cmd};
    do @(posedge clk); while (!s_tready);
    if (!calm && $urandom_range(99) < 14) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // a tick with random pin levels, sometimes carrying a command
  task automatic rand_tick(input int cmd_pct);
    logic [1:0] cmd;
    cmd = ($urandom_range(99) < cmd_pct) ? 2'($urandom_range(1, 3)) : CMD_NONE;
    put_tick(cmd, 8'($urandom), 8'($urandom), 8'($urandom),
             $urandom_range(99) < sda_hi_pct, $urandom_range(99) < 92);
  endtask

  // feed plain ticks until the sequencer is idle, then let the results drain
  task automatic settle();
    s_tvalid <= 0;
    @(posedge clk);
    @(posedge clk);
    while (!bus_idle) begin
      rand_tick(0);
      s_tvalid <= 0;
      @(posedge clk);
      @(posedge clk);
    end
    while (awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] dev, input logic [2:0] att,
                          input logic [3:0] poll, input logic [15:0] gap);
    settle();
    reg_write(REG_DEV, {24'b0, dev});
    reg_write(REG_ATT, {29'b0, att});
    reg_write(REG_POLL, {28'b0, poll});
    reg_write(REG_GAP, {16'b0, gap});
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: every command at reset settings, extreme fields
    put_tick(CMD_WRITE, 8'h00, 8'h00, 8'h00, 1, 1);
    repeat (6) rand_tick(0);
    put_tick(CMD_READ, 8'hFF, 8'hFF, 8'hFF, 1, 1);
    put_tick(CMD_WRITE, 8'h12, 8'h34, 8'h56, 0, 0);   // ignored while busy
    settle();
    put_tick(CMD_MASKED, 8'hA5, 8'hFF, 8'h0F, 0, 0);
    settle();
    put_tick(CMD_NONE, 8'hFF, 8'hFF, 8'hFF, 1, 1);    // idle, nothing starts

    // extremes: one attempt and one poll tick, no gap
    set_regs(8'h00, 3'd1, 4'd1, 16'd0);
    sda_hi_pct = 60;
    put_tick(CMD_MASKED, 8'h00, 8'h00, 8'hFF, 1, 1);
    settle();
    put_tick(CMD_READ, 8'h3C, 8'h00, 8'h00, 1, 1);
    // widest attempt and poll settings
    set_regs(8'hFF, 3'd7, 4'd15, 16'd3);
    sda_hi_pct = 85;
    put_tick(CMD_WRITE, 8'hFF, 8'hFF, 8'h00, 1, 1);
    put_tick(CMD_MASKED, 8'h01, 8'h80, 8'hAA, 1, 1);
    settle();
    // zero attempts and zero poll ticks act as one
    set_regs(8'h5A, 3'd0, 4'd0, 16'd2);
    put_tick(CMD_READ, 8'h80, 8'h01, 8'h01, 1, 1);
    settle();
    // long retry gap: two attempts, SDA kept high so the address fails
    set_regs(8'hC3, 3'd2, 4'd2, 16'd40);
    sda_hi_pct = 100;
    put_tick(CMD_WRITE, 8'h55, 8'hAA, 8'h00, 1, 1);
    settle();

    // random phases with fresh settings; one stretch without idling
    for (int p = 0; p < 5; p++) begin
      set_regs(8'($urandom), 3'($urandom), 4'($urandom), 16'($urandom_range(0, 40)));
      case ($urandom_range(2))
        0: sda_hi_pct = 55;
        1: sda_hi_pct = 75;
        default: sda_hi_pct = 90;
      endcase
      calm = (p == 2);
      for (int i = 0; i < 100; i++) rand_tick(12);
    end
    calm = 0;
    settle();
    s_tvalid <= 0;
    repeat (10) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
